>>> design/sbhm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbhm_pkg;

  // Default sizes handed to the top level
  localparam int DEF_BAR_COUNT    = 64;
  localparam int DEF_HITS_PER_BAR = 64;

  // Field widths
  localparam int EN_W   = 24;   // stored hit energy
  localparam int TM_W   = 21;   // stored hit time
  localparam int D2_W   = 15;   // distance in half-millimetres
  localparam int NUM_W  = 27;   // d2 * log2(e) in Q.12
  localparam int DEN_W  = 17;   // twice the attenuation length
  localparam int TAB_W  = 17;   // 2^-x table entries, Q.16
  localparam int Q_W    = 13;   // attenuation factor, Q.12
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 21;

  localparam logic [12:0] LOG2E_Q12     = 13'd5909;
  localparam logic [39:0] ONE_SECOND_PS = 40'd1000000000000;
  localparam logic [EN_W-1:0] ENERGY_MAX = {EN_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_BAR_LEN   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_DELAY     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ATTEN     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_RESOL     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MAX_TOF   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_THRESH    = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_MAX_HITS  = 3'd6;

  // One stored hit
  typedef struct packed {
    logic            bar_end;
    logic [EN_W-1:0] energy;
    logic [TM_W-1:0] time_ps;
  } hit_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CNT, S_END, S_MUL, S_TEND, S_DIV, S_POW, S_EMUL,
    S_SRD, S_SCHK, S_INS, S_SHR, S_SHW, S_ROR, S_ROC, S_ROF, S_WB
  } state_t;

  // 2^(-k/16) in Q.16
  function automatic logic [TAB_W-1:0] pow2_tab(input logic [4:0] k);
    logic [TAB_W-1:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/scint_bar_hit_merger.sv
// Deposit: per bar end, a restoring divider for the exponent, then a scan of
//   the stored hits and, on insertion, a move of the later hits up one place.
// Readout: the stored hits are read for each end, one hit is held back for
//   the last flag, and output stalls can hold the walk.
// One item at a time. Reset: synchronous, active low; then a clearing pass
//   over all 2*BAR_COUNT count memory entries, during which no item is taken.
`timescale 1ns / 1ps
`default_nettype none

module scint_bar_hit_merger #(
  parameter int BAR_COUNT    = sbhm_pkg::DEF_BAR_COUNT,
  parameter int HITS_PER_BAR = sbhm_pkg::DEF_HITS_PER_BAR
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic        in_plane,
  input  wire logic [1:0]  in_column,
  input  wire logic [5:0]  in_bar,
  input  wire logic signed [12:0] in_x_mm,
  input  wire logic signed [12:0] in_y_mm,
  input  wire logic [39:0] in_t_in_ps,
  input  wire logic [39:0] in_t_out_ps,
  input  wire logic [19:0] in_energy_kev,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_bar_end,
  output logic [23:0]      out_hit_energy_kev,
  output logic [20:0]      out_hit_time_ps,
  output logic             out_overflow,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [sbhm_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [sbhm_pkg::CFG_DW-1:0] cfg_data
);
  import sbhm_pkg::*;

  localparam int SLOTS = 2 * BAR_COUNT;
  localparam int SW    = $clog2(SLOTS);
  localparam int IW    = $clog2(HITS_PER_BAR);
  localparam int CW    = $clog2(HITS_PER_BAR + 1);
  localparam int AW    = SW + IW;

  // Configuration registers
  logic [12:0] bar_len_r;
  logic [15:0] delay_r;
  logic [15:0] atten_r;
  logic [19:0] resol_r;
  logic [20:0] max_tof_r;
  logic [19:0] thresh_r;
  logic [5:0]  max_hits_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_len_r  <= 13'd2520;
      delay_r    <= 16'd1707;
      atten_r    <= 16'd1500;
      resol_r    <= 20'd25000;
      max_tof_r  <= 21'd1000000;
      thresh_r   <= 20'd0;
      max_hits_r <= 6'd25;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BAR_LEN:  bar_len_r  <= cfg_data[12:0];
        CFG_DELAY:    delay_r    <= cfg_data[15:0];
        CFG_ATTEN:    atten_r    <= cfg_data[15:0];
        CFG_RESOL:    resol_r    <= cfg_data[19:0];
        CFG_MAX_TOF:  max_tof_r  <= cfg_data[20:0];
        CFG_THRESH:   thresh_r   <= cfg_data[19:0];
        CFG_MAX_HITS: max_hits_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Hit memory: one read and one write port, registered read data
  hit_t          hs_mem [1 << AW];
  hit_t          hs_rdata_r;
  logic          hs_we, hs_re;
  logic [AW-1:0] hs_waddr, hs_raddr;
  hit_t          hs_wdata;

  always_ff @(posedge clk) begin
    if (hs_we) begin
      hs_mem[hs_waddr] <= hs_wdata;
    end
    if (hs_re) begin
      hs_rdata_r <= hs_mem[hs_raddr];
    end
  end

  // Per-bar count and full flag memory
  logic [CW:0]   cm_mem [SLOTS];
  logic [CW:0]   cm_rdata_r;
  logic          cm_we, cm_re;
  logic [SW-1:0] cm_waddr, cm_raddr;
  logic [CW:0]   cm_wdata;

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cm_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      cm_rdata_r <= cm_mem[cm_raddr];
    end
  end

  // Control and datapath registers
  state_t          state_r, state_nxt;
  logic            act_r, act_nxt;
  logic            plane_r, plane_nxt;
  logic [1:0]      col_r, col_nxt;
  logic signed [12:0] pos_r, pos_nxt;
  logic [39:0]     tin_r, tin_nxt, tout_r, tout_nxt;
  logic [19:0]     e_r, e_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            flag_r, flag_nxt;
  logic            end_r, end_nxt;
  logic [39:0]     t_r, t_nxt;
  logic [D2_W-1:0] d2_r, d2_nxt;
  logic [22:0]     dly_r, dly_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [4:0]      dcnt_r, dcnt_nxt;
  logic [TM_W-1:0] tend_r, tend_nxt;
  logic [Q_W-1:0]  q_r, q_nxt;
  logic [19:0]     de_r, de_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   shj_r, shj_nxt;
  logic [6:0]      k_r, k_nxt;
  hit_t            pend_r, pend_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  logic            out_vld_r, out_vld_nxt;
  hit_t            out_hit_r, out_hit_nxt;
  logic            out_ovf_r, out_ovf_nxt;
  logic            out_last_r, out_last_nxt;
  logic [SW-1:0]   clr_r, clr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    act_r      <= act_nxt;
    plane_r    <= plane_nxt;
    col_r      <= col_nxt;
    pos_r      <= pos_nxt;
    tin_r      <= tin_nxt;
    tout_r     <= tout_nxt;
    e_r        <= e_nxt;
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    flag_r     <= flag_nxt;
    end_r      <= end_nxt;
    t_r        <= t_nxt;
    d2_r       <= d2_nxt;
    dly_r      <= dly_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    tend_r     <= tend_nxt;
    q_r        <= q_nxt;
    de_r       <= de_nxt;
    idx_r      <= idx_nxt;
    shj_r      <= shj_nxt;
    k_r        <= k_nxt;
    pend_r     <= pend_nxt;
    out_hit_r  <= out_hit_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_vld_r;
  assign out_bar_end        = out_hit_r.bar_end;
  assign out_hit_energy_kev = out_hit_r.energy;
  assign out_hit_time_ps    = out_hit_r.time_ps;
  assign out_overflow       = out_ovf_r;
  assign out_last           = out_last_r;

  // Sequencer
  always_comb begin
    logic            done_end;
    logic            push, push_last;
    logic            out_free;
    logic            in_bad;
    logic [SW-1:0]   in_slot;
    logic [40:0]     tsum;
    logic signed [15:0] bl, p2, dn, ds, dsel;
    logic            off0, off1;
    logic [31:0]     dprod;
    logic [40:0]     tend41;
    logic [DEN_W-1:0] den;
    logic [DEN_W:0]  rem_sh;
    logic [TAB_W-1:0] tk, tk1, tdiff, corr, tval, tsh;
    logic [24:0]     cprod;
    logic [TAB_W:0]  qsum;
    logic [32:0]     eprod;
    logic [TM_W-1:0] adiff;
    logic [EN_W:0]   esum;
    logic [5:0]      lim;
    logic [6:0]      cap;
    logic            qual;

    state_nxt    = state_r;
    act_nxt      = act_r;
    plane_nxt    = plane_r;
    col_nxt      = col_r;
    pos_nxt      = pos_r;
    tin_nxt      = tin_r;
    tout_nxt     = tout_r;
    e_nxt        = e_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    flag_nxt     = flag_r;
    end_nxt      = end_r;
    t_nxt        = t_r;
    d2_nxt       = d2_r;
    dly_nxt      = dly_r;
    num_nxt      = num_r;
    rem_nxt      = rem_r;
    dcnt_nxt     = dcnt_r;
    tend_nxt     = tend_r;
    q_nxt        = q_r;
    de_nxt       = de_r;
    idx_nxt      = idx_r;
    shj_nxt      = shj_r;
    k_nxt        = k_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    clr_nxt      = clr_r;
    hs_we        = 1'b0;
    hs_re        = 1'b0;
    hs_waddr     = {slot_r, idx_r[IW-1:0]};
    hs_raddr     = {slot_r, idx_r[IW-1:0]};
    hs_wdata     = hs_rdata_r;
    cm_we        = 1'b0;
    cm_re        = 1'b0;
    cm_waddr     = slot_r;
    cm_wdata     = {flag_r, cnt_r};
    done_end     = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    out_free     = !out_vld_r || out_ready;

    in_bad  = (9'(in_bar) >= 9'(BAR_COUNT));
    in_slot = (in_plane ? SW'(BAR_COUNT) : '0) + SW'(in_bar);
    cm_raddr = in_slot;

    tsum = {1'b0, tin_r} + {1'b0, tout_r};

    bl   = $signed({3'b000, bar_len_r});
    p2   = $signed({{2{pos_r[12]}}, pos_r, 1'b0});
    dn   = bl - p2;
    ds   = bl + p2;
    off0 = (!plane_r && col_r == 2'd1) || (plane_r && col_r == 2'd2);
    off1 = (!plane_r && col_r == 2'd2) || (plane_r && col_r == 2'd1);
    dsel = end_r ? ds : dn;

    dprod  = 32'(d2_r) * 32'(delay_r) + 32'd256;
    tend41 = {1'b0, t_r} + 41'(dly_r);

    den    = (atten_r == 16'd0) ? 17'd2 : {atten_r, 1'b0};
    rem_sh = {rem_r, num_r[NUM_W-1]};

    tk    = pow2_tab({1'b0, num_r[11:8]});
    tk1   = pow2_tab({1'b0, num_r[11:8]} + 5'd1);
    tdiff = tk - tk1;
    cprod = 25'(tdiff) * 25'(num_r[7:0]) + 25'd128;
    corr  = cprod[24:8];
    tval  = tk - corr;
    tsh   = tval >> num_r[16:12];
    qsum  = {1'b0, tsh} + 18'd8;

    eprod = 33'(e_r) * 33'(q_r) + 33'd2048;

    adiff = (hs_rdata_r.time_ps > tend_r) ? (hs_rdata_r.time_ps - tend_r)
                                          : (tend_r - hs_rdata_r.time_ps);
    esum  = {1'b0, hs_rdata_r.energy} + (EN_W + 1)'(de_r);

    lim  = (max_hits_r > 6'd32) ? 6'd32 : max_hits_r;
    cap  = {lim, 1'b0};
    qual = (hs_rdata_r.bar_end == end_r) &&
           (hs_rdata_r.energy > {4'b0000, thresh_r});

    case (state_r)
      // clear the count memory after reset
      S_CLR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_r;
        cm_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == SW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // take an item and fetch its bar's count
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          plane_nxt = in_plane;
          col_nxt   = in_column;
          pos_nxt   = in_plane ? in_x_mm : in_y_mm;
          tin_nxt   = in_t_in_ps;
          tout_nxt  = in_t_out_ps;
          e_nxt     = in_energy_kev;
          slot_nxt  = in_slot;
          if (!in_bad && (in_action || in_energy_kev != 20'd0)) begin
            cm_re     = 1'b1;
            state_nxt = S_CNT;
          end
        end
      end

      S_CNT: begin
        cnt_nxt      = cnt_r;
        {flag_nxt, cnt_nxt} = cm_rdata_r;
        end_nxt      = 1'b0;
        idx_nxt      = '0;
        k_nxt        = '0;
        pend_vld_nxt = 1'b0;
        t_nxt        = (tout_r > ONE_SECOND_PS) ? tin_r : tsum[40:1];
        state_nxt    = act_r ? S_ROR : S_END;
      end

      // distance to this end
      S_END: begin
        if ((end_r && off1) || (!end_r && off0)) begin
          done_end = 1'b1;
        end else begin
          d2_nxt    = dsel[15] ? '0 : dsel[D2_W-1:0];
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        dly_nxt   = dprod[31:9];
        num_nxt   = NUM_W'(28'(d2_r) * 28'(LOG2E_Q12));
        state_nxt = S_TEND;
      end

      S_TEND: begin
        if (tend41 >= 41'(max_tof_r)) begin
          done_end = 1'b1;
        end else begin
          tend_nxt  = tend41[TM_W-1:0];
          rem_nxt   = '0;
          dcnt_nxt  = 5'(NUM_W - 1);
          state_nxt = S_DIV;
        end
      end

      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (rem_sh >= {1'b0, den}) begin
          rem_nxt = DEN_W'(rem_sh - {1'b0, den});
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DEN_W-1:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 5'd1;
        if (dcnt_r == 5'd0) begin
          state_nxt = S_POW;
        end
      end

      // 2^-u by table and interpolation
      S_POW: begin
        if (num_r[NUM_W-1:12] >= 15'd17) begin
          done_end = 1'b1;
        end else begin
          q_nxt     = qsum[16:4];
          state_nxt = S_EMUL;
        end
      end

      S_EMUL: begin
        de_nxt  = eprod[31:12];
        idx_nxt = '0;
        if (eprod[31:12] == 20'd0) begin
          done_end = 1'b1;
        end else begin
          state_nxt = S_SRD;
        end
      end

      // walk the bar's list
      S_SRD: begin
        if (idx_r < cnt_r) begin
          hs_re     = 1'b1;
          state_nxt = S_SCHK;
        end else begin
          state_nxt = S_INS;
        end
      end

      S_SCHK: begin
        if (hs_rdata_r.bar_end != end_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRD;
        end else if (adiff < {1'b0, resol_r}) begin
          hs_we            = 1'b1;
          hs_wdata.bar_end = end_r;
          hs_wdata.energy  = esum[EN_W] ? ENERGY_MAX : esum[EN_W-1:0];
          hs_wdata.time_ps = (hs_rdata_r.time_ps > tend_r) ? tend_r
                                                            : hs_rdata_r.time_ps;
          done_end         = 1'b1;
        end else if (hs_rdata_r.time_ps > tend_r) begin
          state_nxt = S_INS;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end

      S_INS: begin
        if (cnt_r >= CW'(HITS_PER_BAR)) begin
          flag_nxt = 1'b1;
          done_end = 1'b1;
        end else begin
          shj_nxt   = cnt_r;
          state_nxt = S_SHR;
        end
      end

      // move later hits up one place, then write the new one
      S_SHR: begin
        if (shj_r > idx_r) begin
          hs_re     = 1'b1;
          hs_raddr  = {slot_r, IW'(shj_r - 1'b1)};
          state_nxt = S_SHW;
        end else begin
          hs_we            = 1'b1;
          hs_wdata.bar_end = end_r;
          hs_wdata.energy  = EN_W'(de_r);
          hs_wdata.time_ps = tend_r;
          cnt_nxt          = cnt_r + 1'b1;
          done_end         = 1'b1;
        end
      end

      S_SHW: begin
        hs_we     = 1'b1;
        hs_waddr  = {slot_r, shj_r[IW-1:0]};
        hs_wdata  = hs_rdata_r;
        shj_nxt   = shj_r - 1'b1;
        state_nxt = S_SHR;
      end

      // readout walk, one end after the other
      S_ROR: begin
        if (idx_r < cnt_r && k_r < cap) begin
          hs_re     = 1'b1;
          state_nxt = S_ROC;
        end else if (!end_r) begin
          end_nxt = 1'b1;
          idx_nxt = '0;
        end else begin
          state_nxt = S_ROF;
        end
      end

      // one hit is held back so the last flag is known
      S_ROC: begin
        if (!qual) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_ROR;
        end else if (!pend_vld_r || out_free) begin
          push         = pend_vld_r;
          pend_nxt     = hs_rdata_r;
          pend_vld_nxt = 1'b1;
          k_nxt        = k_r + 7'd1;
          idx_nxt      = idx_r + 1'b1;
          state_nxt    = S_ROR;
        end
      end

      S_ROF: begin
        if (!pend_vld_r || out_free) begin
          push         = pend_vld_r;
          push_last    = 1'b1;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          flag_nxt     = 1'b0;
          state_nxt    = S_WB;
        end
      end

      S_WB: begin
        cm_we     = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // advance to the other end or finish the deposit
    if (done_end) begin
      if (!end_r) begin
        end_nxt   = 1'b1;
        state_nxt = S_END;
      end else begin
        state_nxt = S_WB;
      end
    end

    // output register
    out_hit_nxt  = out_hit_r;
    out_ovf_nxt  = out_ovf_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_vld_nxt  = 1'b1;
      out_hit_nxt  = pend_r;
      out_ovf_nxt  = flag_r;
      out_last_nxt = push_last;
    end else if (out_ready) begin
      out_vld_nxt  = 1'b0;
    end else begin
      out_vld_nxt  = out_vld_r;
    end
  end

  // Checks
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("held readout hit left behind at item end");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLR && state_r != S_IDLE && state_r != S_CNT) |->
      (cnt_r <= CW'(HITS_PER_BAR)))
    else $error("bar hit count beyond list depth");

  a_no_hit_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!hs_we && !in_ready))
    else $error("activity during count clearing pass");

  a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_hit_time_ps) && out_valid))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
